/* hdl/rle_palette_pattern_decoder_unit_defines.svh */
// Assertion macros shared by the run-length palette pattern decoder.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef RLE_PALETTE_PATTERN_DECODER_UNIT_DEFINES_SVH
`define RLE_PALETTE_PATTERN_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RPPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RPPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rppd_pkg.sv */
// Package of the run-length palette pattern decoder: phase codes, widths,
// result structs and the fixed 256-entry ARGB palette ROM. No dependencies.
package rppd_pkg;

  localparam int unsigned MaxColorsDef = 16;

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhPalette = 2'd1;
  localparam logic [1:0] PhRuns    = 2'd2;
  localparam logic [1:0] PhDone    = 2'd3;

  localparam logic [7:0] KeyIndex = 8'd245;

  localparam int unsigned SDataW = 8;
  localparam int unsigned MDataW = 80;

  typedef struct packed {
    logic [7:0]  image_height;
    logic [7:0]  image_width;
    logic [31:0] argb_color;
    logic [8:0]  span_count;
    logic [15:0] span_start;
  } rppd_span_t;

  typedef struct packed {
    logic       produce;
    logic [1:0] phase;
    logic       colorkey_on;
  } rppd_stat_t;

  typedef logic [31:0] argb_rom_t [256];

  // System colors, the 6x6x6 web cube, a gap of zeros and the special colors.
  function automatic argb_rom_t build_argb_rom();
    argb_rom_t rom;
    int        idx;
    for (int i = 0; i < 256; i++) begin
      rom[i] = 32'h0;
    end
    rom[0] = 32'h00000000;
    rom[1] = 32'h00800000;
    rom[2] = 32'h00008000;
    rom[3] = 32'h00808000;
    rom[4] = 32'h00000080;
    rom[5] = 32'h00800080;
    rom[6] = 32'h00008080;
    rom[7] = 32'h00c0c0c0;
    rom[8] = 32'h00c0dcc0;
    rom[9] = 32'h00a6caf0;
    for (int r = 0; r < 6; r++) begin
      for (int g = 0; g < 6; g++) begin
        for (int b = 0; b < 6; b++) begin
          idx = 10 + r * 36 + g * 6 + b;
          rom[idx] = {8'h00, 8'(r * 51), 8'(g * 51), 8'(b * 51)};
        end
      end
    end
    rom[245] = 32'hff010101;
    rom[246] = 32'h00fffbf0;
    rom[247] = 32'h00a0a0a4;
    rom[248] = 32'h00808080;
    rom[249] = 32'h00ff0000;
    rom[250] = 32'h0000ff00;
    rom[251] = 32'h00ffff00;
    rom[252] = 32'h000000ff;
    rom[253] = 32'h00ff00ff;
    rom[254] = 32'h0000ffff;
    rom[255] = 32'h00ffffff;
    return rom;
  endfunction

  localparam argb_rom_t ArgbRom = build_argb_rom();

endpackage

/* hdl/rle_palette_pattern_decoder_unit.sv */
// Top level of the run-length palette pattern decoder: input word register,
// result register and stream handshakes. Depends on rppd_pkg and rppd_decode.
//
// Usage: the slave stream carries one pattern byte per word in s_axis_tdata,
// with s_axis_tuser high on byte 0 of each record. The header (length low and
// high byte, format, width, height) and the palette-index bytes give no output.
// Each run byte before the last byte of the record gives one span word on the
// master stream; the final byte of a record is consumed without output unless
// its length is zero. A word accepted into the input register is decoded by
// one pass of logic (palette lookup, ROM read, clip against width times
// height) and lands in the result register, where m_axis_tvalid is raised;
// a full result register may hold it back. Throughput is one word per cycle
// without stalls, set by the single parse-state update per byte.
// When the receiver holds m_axis_tready low, the result register keeps its
// word and the input register still accepts bytes; a byte that would give
// another span waits there, and s_axis_tready drops until the result
// register is freed. Header and palette bytes pass even during a stall.
// Reset clears both valid flags, the parse phase and all header fields. The
// local palette is not cleared; a record always fills it before reading it.
`include "rle_palette_pattern_decoder_unit_defines.svh"

module rle_palette_pattern_decoder_unit import rppd_pkg::*; #(
  parameter int unsigned MAX_COLORS = MaxColorsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SDataW-1:0] s_axis_tdata,  // [7:0] pattern_byte
  input  logic [0:0]        s_axis_tuser,  // [0] record_start
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [15:0] span_start, [24:16] span_count, [56:25] argb_color,
  // [64:57] image_width, [72:65] image_height, [79:73] zero
  output logic [MDataW-1:0] m_axis_tdata,
  output logic [0:0]        m_axis_tuser   // [0] colorkey_on
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       s1_adv;
  logic       out_free;
  logic       s_accept;

  logic       m_valid_q, m_valid_d;
  rppd_span_t m_span_q;
  logic       m_key_q;

  rppd_stat_t dec_stat;
  rppd_span_t dec_span;

  rppd_decode #(
    .MAX_COLORS(MAX_COLORS)
  ) u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_adv),
    .pattern_byte_i(s1_byte_q),
    .record_start_i(s1_start_q),
    .stat_o        (dec_stat),
    .span_o        (dec_span)
  );

  // A byte that gives no span never waits for the receiver.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!dec_stat.produce || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d = s_axis_tready ? s_axis_tvalid : s1_valid_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (s1_adv && dec_stat.produce) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_byte_q  <= s_axis_tdata[7:0];
      s1_start_q <= s_axis_tuser[0];
    end
    if (s1_adv && dec_stat.produce) begin
      m_span_q <= dec_span;
      m_key_q  <= dec_stat.colorkey_on;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_span_q};
  assign m_axis_tuser  = m_key_q;

  // Checks: spans stay inside the image, stalls come only from a full
  // result register, and spans come only from the run phase.
  logic [16:0] span_end;
  logic [16:0] span_area;

  assign span_end  = {1'b0, m_span_q.span_start} + {8'd0, m_span_q.span_count};
  assign span_area = {9'd0, m_span_q.image_width} * {9'd0, m_span_q.image_height};

  `RPPD_ASSERT_NOW(a_span_in_area, m_valid_q, span_end <= span_area, "span beyond image")
  `RPPD_ASSERT_NOW(a_stall_full, s1_valid_q && !s1_adv, m_valid_q && !m_axis_tready, "bad stall")
  `RPPD_ASSERT_NOW(a_span_phase, s1_valid_q && dec_stat.produce, dec_stat.phase == PhRuns, "span off run phase")
  `RPPD_ASSERT_NEXT(a_span_shown, s1_adv && dec_stat.produce, m_valid_q, "span not presented")

endmodule

/* hdl/rppd_decode.sv */
// Record parser and span generator of the run-length palette pattern decoder.
// Holds all parse state and the local palette; depends on rppd_pkg.
module rppd_decode import rppd_pkg::*; #(
  parameter int unsigned MAX_COLORS = MaxColorsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] pattern_byte_i,
  input  logic       record_start_i,
  output rppd_stat_t stat_o,
  output rppd_span_t span_o
);

  localparam int unsigned PalAw  = $clog2(MAX_COLORS);
  localparam logic [2:0]  MaxFmt = 3'($clog2(MAX_COLORS + 1) - 1);

  logic [1:0]  phase_q, phase_d, phase_c;
  logic [15:0] pos_q, pos_d, pos_c;
  logic [15:0] len_q, len_d;
  logic [2:0]  fmt_q, fmt_d;
  logic [7:0]  width_q, width_d;
  logic [7:0]  height_q, height_d;
  logic [15:0] pix_q, pix_d, pix_c;
  logic        key_q, key_d, key_c;
  logic [7:0]  pal_q [MAX_COLORS];

  logic [15:0]      pal_off;
  logic [3:0]       pal_k;
  logic [4:0]       n_colors;
  logic             pal_last;
  logic [7:0]       idx_mask;
  logic [7:0]       idx_full;
  logic [PalAw-1:0] idx_local;
  logic [8:0]       run_len;
  logic [15:0]      area;
  logic [15:0]      avail;
  logic [8:0]       cnt;
  logic             in_run;

  // A record start makes this byte byte 0 of a fresh record.
  assign phase_c = record_start_i ? PhHeader : phase_q;
  assign pos_c   = record_start_i ? 16'd0 : pos_q;
  assign pix_c   = record_start_i ? 16'd0 : pix_q;
  assign key_c   = record_start_i ? 1'b0 : key_q;

  assign pal_off  = pos_c - 16'd5;
  assign pal_k    = pal_off[3:0];
  assign n_colors = 5'd1 << fmt_q;
  assign pal_last = ({1'b0, pal_k} + 5'd1) >= n_colors;

  assign idx_mask  = 8'((9'd1 << fmt_q) - 9'd1);
  assign idx_full  = pattern_byte_i & idx_mask;
  assign idx_local = idx_full[PalAw-1:0];
  assign run_len   = {1'b0, pattern_byte_i >> fmt_q} + 9'd1;
  assign area      = {8'd0, width_q} * {8'd0, height_q};
  assign avail     = (pix_c < area) ? (area - pix_c) : 16'd0;
  assign cnt       = ({7'd0, run_len} < avail) ? run_len : avail[8:0];
  assign in_run    = (phase_c == PhRuns) && (pos_c < len_q);

  assign stat_o.produce     = in_run;
  assign stat_o.phase       = phase_c;
  assign stat_o.colorkey_on = key_c;

  assign span_o.span_start   = pix_c;
  assign span_o.span_count   = cnt;
  assign span_o.argb_color   = ArgbRom[pal_q[idx_local]];
  assign span_o.image_width  = width_q;
  assign span_o.image_height = height_q;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    len_d    = len_q;
    fmt_d    = fmt_q;
    width_d  = width_q;
    height_d = height_q;
    pix_d    = pix_q;
    key_d    = key_q;
    if (step_i) begin
      phase_d = phase_c;
      pix_d   = pix_c;
      key_d   = key_c;
      pos_d   = (pos_c != 16'hffff) ? (pos_c + 16'd1) : pos_c;
      unique case (phase_c)
        PhHeader: begin
          unique case (pos_c)
            16'd0: len_d = {8'd0, pattern_byte_i};
            // The stored length is L-1, the first position that is not decoded.
            16'd1: len_d = {pattern_byte_i, len_q[7:0]} - 16'd1;
            16'd2: fmt_d = (pattern_byte_i > {5'd0, MaxFmt}) ? MaxFmt : pattern_byte_i[2:0];
            16'd3: width_d = pattern_byte_i;
            default: begin
              height_d = pattern_byte_i;
              phase_d  = PhPalette;
            end
          endcase
        end
        PhPalette: begin
          if (pattern_byte_i == KeyIndex) begin
            key_d = 1'b1;
          end
          if (pal_last) begin
            phase_d = PhRuns;
          end
        end
        PhRuns: begin
          if (in_run) begin
            pix_d = pix_c + {7'd0, cnt};
          end else begin
            phase_d = PhDone;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      pos_q    <= 16'd0;
      len_q    <= 16'd0;
      fmt_q    <= 3'd0;
      width_q  <= 8'd0;
      height_q <= 8'd0;
      pix_q    <= 16'd0;
      key_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      fmt_q    <= fmt_d;
      width_q  <= width_d;
      height_q <= height_d;
      pix_q    <= pix_d;
      key_q    <= key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && (phase_c == PhPalette)) begin
      pal_q[pal_k[PalAw-1:0]] <= pattern_byte_i;
    end
  end

endmodule

/* verif/rle_palette_pattern_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for rle_palette_pattern_decoder_unit. It streams pattern records
// into the decoder and checks each span word against a behavioral decoder kept in the bench.
// Depends on rppd_pkg and on the decoder RTL.
module rle_palette_pattern_decoder_unit_tb;
  import rppd_pkg::*;

  // Largest format whose palette still fits in MaxColorsDef entries.
  localparam int unsigned FmtLimit    = $clog2(MaxColorsDef + 1) - 1;
  localparam int unsigned TargetWords = 1900;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned SpanW       = $bits(rppd_span_t);

  typedef struct {
    logic [7:0]  data;
    logic        start;
    int unsigned gap;    // idle cycles after this word is taken
    bit          drain;  // hold this word back until every span has come out
  } pattern_word_t;

  typedef struct {
    rppd_span_t span;
    logic       key;
  } span_word_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SDataW-1:0] s_axis_tdata  = '0;  // [7:0] pattern_byte
  logic [0:0]        s_axis_tuser  = '0;  // [0] record_start
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [15:0] span_start, [24:16] span_count, [56:25] argb_color,
  // [64:57] image_width, [72:65] image_height, [79:73] zero
  logic [MDataW-1:0] m_axis_tdata;
  logic [0:0]        m_axis_tuser;   // [0] colorkey_on

  pattern_word_t pattern_words [$];
  span_word_t    pending_spans [$];
  int unsigned   mismatches   = 0;
  int unsigned   words_queued = 0;
  int unsigned   cycle_count  = 0;
  bit            calm_stretch = 1'b0;
  bit            drain_next   = 1'b0;

  // Decoder state as the bench sees it.
  logic [1:0]  dec_phase   = PhHeader;
  logic [15:0] dec_pos     = '0;
  logic [15:0] dec_len     = '0;
  logic [2:0]  dec_fmt     = '0;
  logic [7:0]  dec_width   = '0;
  logic [7:0]  dec_height  = '0;
  logic [7:0]  dec_palette [16] = '{default: 8'h00};
  logic [15:0] dec_pix     = '0;
  logic        dec_key     = 1'b0;

  // Fixed colors at both ends of the palette ROM; between them the web cube and zeros.
  logic [31:0] sys_colors [10] = '{
    32'h00000000, 32'h00800000, 32'h00008000, 32'h00808000, 32'h00000080,
    32'h00800080, 32'h00008080, 32'h00c0c0c0, 32'h00c0dcc0, 32'h00a6caf0};
  logic [31:0] special_colors [11] = '{
    32'hff010101, 32'h00fffbf0, 32'h00a0a0a4, 32'h00808080, 32'h00ff0000,
    32'h0000ff00, 32'h00ffff00, 32'h000000ff, 32'h00ff00ff, 32'h0000ffff,
    32'h00ffffff};

  // Record sent without record_start: format 0, a 4x2 image keyed by index 245,
  // a 256-pixel run clipped to 8, then a run that starts past the end.
  logic [7:0] unflagged_record [9] = '{
    8'h09, 8'h00, 8'h00, 8'h04, 8'h02, 8'hf5, 8'hff, 8'h03, 8'h00};
  // Zero length (no end marker), oversized format, full 255x255 image and a
  // palette that touches every region of the color ROM.
  logic [7:0] wide_record [24] = '{
    8'h00, 8'h00, 8'hff, 8'hff, 8'hff,
    8'h00, 8'hff, 8'h09, 8'h0a, 8'he1, 8'he2, 8'hf4, 8'hf5,
    8'hf6, 8'h07, 8'h08, 8'h81, 8'h55, 8'h33, 8'hc8, 8'hf0,
    8'hff, 8'h10, 8'h2e};

  rle_palette_pattern_decoder_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Advances the bench decoder by one accepted pattern byte and queues the
  // span that a run byte produces.
  task automatic decode_pattern_word(input logic [7:0] pb, input logic rs);
    logic [15:0] pos;
    logic [31:0] argb;
    int unsigned slot, total, avail, run_len, cnt, sel, cube;
    span_word_t  sw;
    if (rs) begin
      dec_phase = PhHeader;
      dec_pos   = '0;
      dec_pix   = '0;
      dec_key   = 1'b0;
    end
    pos = dec_pos;
    case (dec_phase)
      PhHeader: begin
        case (pos)
          16'd0: dec_len = {8'h00, pb};
          16'd1: dec_len = {pb, dec_len[7:0]} - 16'd1;
          16'd2: dec_fmt = (int'(pb) > FmtLimit) ? 3'(FmtLimit) : pb[2:0];
          16'd3: dec_width = pb;
          default: begin
            dec_height = pb;
            dec_phase  = PhPalette;
          end
        endcase
      end
      PhPalette: begin
        slot = int'((pos - 16'd5) & 16'h000f);
        dec_palette[slot] = pb;
        if (pb == KeyIndex) dec_key = 1'b1;
        if (slot + 1 >= (1 << dec_fmt)) dec_phase = PhRuns;
      end
      PhRuns: begin
        if (pos < dec_len) begin
          run_len = (int'(pb) >> dec_fmt) + 1;
          total   = int'(dec_width) * int'(dec_height);
          avail   = (int'(dec_pix) < total) ? total - int'(dec_pix) : 0;
          cnt     = (run_len < avail) ? run_len : avail;
          sel     = int'(dec_palette[int'(pb) & ((1 << dec_fmt) - 1)]);
          if (sel < 10) begin
            argb = sys_colors[sel];
          end else if (sel < 226) begin
            cube = sel - 10;
            argb = {8'h00, 8'(cube / 36 * 51), 8'(cube / 6 % 6 * 51), 8'(cube % 6 * 51)};
          end else if (sel < 245) begin
            argb = '0;
          end else begin
            argb = special_colors[sel - 245];
          end
          sw.span.span_start   = dec_pix;
          sw.span.span_count   = 9'(cnt);
          sw.span.argb_color   = argb;
          sw.span.image_width  = dec_width;
          sw.span.image_height = dec_height;
          sw.key               = dec_key;
          pending_spans.push_back(sw);
          dec_pix = 16'(int'(dec_pix) + cnt);
        end else begin
          dec_phase = PhDone;
        end
      end
      default: ;
    endcase
    if (dec_pos != 16'hffff) dec_pos = dec_pos + 16'd1;
  endtask

  // Queues one pattern byte with a random idle gap after it. Bytes that the
  // decoder will only skip are not counted toward the stimulus size.
  task automatic push_word(input logic [7:0] data, input logic start, input bit counted);
    pattern_word_t w;
    int unsigned   roll;
    roll    = $urandom_range(0, 99);
    w.data  = data;
    w.start = start;
    w.drain = drain_next;
    drain_next = 1'b0;
    if (calm_stretch || roll < 55) w.gap = 0;
    else if (roll < 90) w.gap = $urandom_range(1, 3);
    else w.gap = $urandom_range(8, 40);
    pattern_words.push_back(w);
    if (counted) words_queued++;
  endtask

  task automatic flag_mismatch(input string what, input logic [79:0] want,
                               input logic [79:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d at %0t ns: %s expected %0h got %0h",
               mismatches, $time, what, want, got);
    end
  endtask

  // Source side: one word at a time from the queue, with gaps between words.
  bit            send_next;
  int unsigned   gap_left;
  pattern_word_t next_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      send_next = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_pattern_word(s_axis_tdata, s_axis_tuser[0]);
        send_next = 1'b0;
      end
      if (!send_next && pattern_words.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pattern_words[0].drain && pending_spans.size() != 0)) begin
          next_word = pattern_words.pop_front();
          s_axis_tdata <= next_word.data;
          s_axis_tuser <= next_word.start;
          gap_left  = next_word.gap;
          send_next = 1'b1;
        end
      end
      // Single assignment per edge, so a word held high stays high.
      s_axis_tvalid <= send_next;
    end
  end

  // Sink side: random back-pressure and a field-by-field compare of each span.
  int unsigned stall_left = 0;
  bit          free_flow  = 1'b0;
  rppd_span_t  got_span;
  span_word_t  want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_span = m_axis_tdata[SpanW-1:0];
        if (pending_spans.size() == 0) begin
          flag_mismatch("span word with nothing pending", '0, m_axis_tdata);
        end else begin
          want = pending_spans.pop_front();
          if (got_span.span_start !== want.span.span_start)
            flag_mismatch("span_start", 80'(want.span.span_start),
                          80'(got_span.span_start));
          if (got_span.span_count !== want.span.span_count)
            flag_mismatch("span_count", 80'(want.span.span_count),
                          80'(got_span.span_count));
          if (got_span.argb_color !== want.span.argb_color)
            flag_mismatch("argb_color", 80'(want.span.argb_color),
                          80'(got_span.argb_color));
          if (got_span.image_width !== want.span.image_width)
            flag_mismatch("image_width", 80'(want.span.image_width),
                          80'(got_span.image_width));
          if (got_span.image_height !== want.span.image_height)
            flag_mismatch("image_height", 80'(want.span.image_height),
                          80'(got_span.image_height));
          if (m_axis_tdata[MDataW-1:SpanW] !== '0)
            flag_mismatch("pad bits", '0, 80'(m_axis_tdata[MDataW-1:SpanW]));
          if (m_axis_tuser[0] !== want.key)
            flag_mismatch("colorkey_on", 80'(want.key), 80'(m_axis_tuser[0]));
        end
      end
      // Now and then switch between a stalling sink and one that never stalls.
      if ($urandom_range(0, 499) == 0) free_flow = !free_flow;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!free_flow && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned kind, noise_len, fmt_byte, colors, img_w, img_h, runs;
    int unsigned rec_len, cut, last_run;
    logic [7:0]  b;
    bit          drained_once;
    drained_once = 1'b0;

    // Opening records: one without a start flag right after reset, then a
    // full-size record with every ROM region and a saturated format.
    for (int i = 0; i < 9; i++) push_word(unflagged_record[i], 1'b0, 1'b1);
    for (int i = 0; i < 24; i++) push_word(wide_record[i], i == 0, 1'b1);

    // Mostly well-formed records with random content; the rest are records
    // with odd lengths, records cut short by the next start, and plain noise.
    while (words_queued < TargetWords) begin
      if ($urandom_range(0, 9) == 0) calm_stretch = !calm_stretch;
      if (!drained_once && words_queued > TargetWords / 2) begin
        drain_next   = 1'b1;
        drained_once = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind >= 88) begin
        noise_len = $urandom_range(3, 24);
        for (int i = 0; i < noise_len; i++) begin
          push_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
        end
      end else begin
        fmt_byte = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
        colors   = 1 << ((fmt_byte > FmtLimit) ? FmtLimit : fmt_byte);
        if ($urandom_range(0, 4) == 0) begin
          img_w = $urandom_range(0, 255);
          img_h = $urandom_range(0, 255);
        end else begin
          img_w = $urandom_range(0, 12);
          img_h = $urandom_range(0, 12);
        end
        runs    = $urandom_range(1, 14);
        rec_len = 5 + colors + runs + 1;
        cut     = rec_len;
        if (kind >= 70) begin
          case ($urandom_range(0, 3))
            0:       rec_len = 0;
            1:       rec_len = $urandom_range(1, 8);
            2:       rec_len = $urandom_range(0, 65535);
            default: cut = $urandom_range(1, rec_len - 1);
          endcase
        end
        last_run = (rec_len - 1) & 16'hffff;
        for (int i = 0; i < cut; i++) begin
          case (i)
            0: b = rec_len[7:0];
            1: b = rec_len[15:8];
            2: b = 8'(fmt_byte);
            3: b = 8'(img_w);
            4: b = 8'(img_h);
            default: begin
              if (i < 5 + colors && $urandom_range(0, 9) == 0) b = KeyIndex;
              else b = 8'($urandom_range(0, 255));
            end
          endcase
          push_word(b, i == 0, (i < 5 + colors) || (i <= last_run));
        end
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pattern_words.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (pending_spans.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
